[hdl/lzwge_pkg.sv]
// Package for the GIF LZW encoder: default sizes and the structs passed
// between the sequencer, the dictionary and the bit packer. No dependencies.
package lzwge_pkg;

	localparam int PIXEL_BITS_DEF    = 8;
	localparam int MAX_CODE_BITS_DEF = 12;
	localparam int TABLE_ENTRIES_DEF = 4096;

	localparam int CODE_W  = 12;
	localparam int WIDTH_W = 4;
	localparam int ADDR_W  = 12;
	localparam int LINK_W  = 13;
	localparam int SYM_W   = 8;

	// one code handed to the packer; fin pads to a byte and marks the final byte
	typedef struct packed {
		logic               put;
		logic [CODE_W-1:0]  code;
		logic [WIDTH_W-1:0] width;
		logic               fin;
	} put_t;

	// dictionary write requests
	typedef struct packed {
		logic              ent_we;
		logic [ADDR_W-1:0] ent_addr;
		logic [SYM_W-1:0]  sym;
		logic [LINK_W-1:0] sib;
		logic              fc_we;
		logic [ADDR_W-1:0] fc_addr;
		logic [LINK_W-1:0] fc_data;
		logic              clear_roots;
	} dict_wr_t;

endpackage

[hdl/lzwge_dict.sv]
// Trie dictionary: symbol, first-child and next-sibling memories with
// registered reads, plus per-root valid bits for the first-child links.
// Depends on lzwge_pkg.
module lzwge_dict #(
	parameter int PIXEL_BITS    = lzwge_pkg::PIXEL_BITS_DEF,
	parameter int TABLE_ENTRIES = lzwge_pkg::TABLE_ENTRIES_DEF,
	localparam int AW = $clog2(TABLE_ENTRIES),
	localparam int LW = $clog2(TABLE_ENTRIES + 1),
	localparam int ROOTS = 1 << PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lzwge_pkg::dict_wr_t   wr,
	input  logic [LW-1:0]         fc_raddr,
	input  logic [LW-1:0]         link_raddr,
	output logic [LW-1:0]         fc_rdata,
	output logic [PIXEL_BITS-1:0] sym_rdata,
	output logic [LW-1:0]         sib_rdata
);

	localparam logic [LW-1:0] NO_LINK = LW'(TABLE_ENTRIES);

	logic [PIXEL_BITS-1:0] sym_mem [TABLE_ENTRIES];
	logic [LW-1:0]         sib_mem [TABLE_ENTRIES];
	logic [LW-1:0]         fc_mem  [TABLE_ENTRIES];

	logic [ROOTS-1:0]      root_v_q;
	logic [LW-1:0]         fc_rd_q;
	logic                  root_hit_q;
	logic [PIXEL_BITS-1:0] root_idx_q;
	logic [PIXEL_BITS-1:0] sym_rd_q;
	logic [LW-1:0]         sib_rd_q;

	always_ff @(posedge clk) begin
		if (wr.ent_we) begin
			sym_mem[AW'(wr.ent_addr)] <= PIXEL_BITS'(wr.sym);
			sib_mem[AW'(wr.ent_addr)] <= LW'(wr.sib);
		end
		if (wr.fc_we) begin
			fc_mem[AW'(wr.fc_addr)] <= LW'(wr.fc_data);
		end
		fc_rd_q    <= fc_mem[fc_raddr[AW-1:0]];
		root_hit_q <= (fc_raddr < LW'(ROOTS));
		root_idx_q <= fc_raddr[PIXEL_BITS-1:0];
		sym_rd_q   <= sym_mem[link_raddr[AW-1:0]];
		sib_rd_q   <= sib_mem[link_raddr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_v_q <= '0;
		end else if (wr.clear_roots) begin
			root_v_q <= '0;
		end else if (wr.fc_we && (wr.fc_addr < lzwge_pkg::ADDR_W'(ROOTS))) begin
			root_v_q[PIXEL_BITS'(wr.fc_addr)] <= 1'b1;
		end
	end

	assign fc_rdata  = (root_hit_q && !root_v_q[root_idx_q]) ? NO_LINK : fc_rd_q;
	assign sym_rdata = sym_rd_q;
	assign sib_rdata = sib_rd_q;

endmodule

[hdl/lzwge_pack.sv]
// Bit packer: merges variable-width codes LSB first and drives the byte
// output register with valid/stall. Depends on lzwge_pkg.
module lzwge_pack (
	input  logic            clk,
	input  logic            arst_n,
	input  lzwge_pkg::put_t put,
	output logic            ready,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      data_byte,
	output logic            last_byte
);

	logic [23:0] acc_q;
	logic [4:0]  held_q;
	logic        fin_q;
	logic        ov_q;
	logic [7:0]  byte_q;
	logic        lastb_q;
	logic        load;
	logic [11:0] mask;
	logic [4:0]  sum;

	assign ready = (held_q < 5'd8);
	assign load  = (held_q >= 5'd8) && (!ov_q || !out_stall);
	assign mask  = 12'((13'd1 << put.width) - 13'd1);
	assign sum   = held_q + 5'(put.width);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			held_q  <= '0;
			fin_q   <= 1'b0;
			ov_q    <= 1'b0;
			byte_q  <= '0;
			lastb_q <= 1'b0;
		end else begin
			if (load) begin
				ov_q    <= 1'b1;
				byte_q  <= acc_q[7:0];
				lastb_q <= fin_q && (held_q == 5'd8);
				acc_q   <= acc_q >> 8;
				held_q  <= held_q - 5'd8;
				if (held_q == 5'd8) begin
					fin_q <= 1'b0;
				end
			end else begin
				if (ov_q && !out_stall) begin
					ov_q <= 1'b0;
				end
				if (put.put && ready) begin
					acc_q <= acc_q | (24'(put.code & mask) << held_q);
					if (put.fin) begin
						held_q <= (sum + 5'd7) & 5'b11000;
						fin_q  <= 1'b1;
					end else begin
						held_q <= sum;
					end
				end
			end
		end
	end

	assign out_valid = ov_q;
	assign data_byte = byte_q;
	assign last_byte = lastb_q;

endmodule

[hdl/lzwge_ctrl.sv]
// Sequencer: trie walk through the dictionary, entry insertion, code width
// and restart handling, and code hand-off to the packer. Depends on lzwge_pkg.
module lzwge_ctrl #(
	parameter int PIXEL_BITS    = lzwge_pkg::PIXEL_BITS_DEF,
	parameter int MAX_CODE_BITS = lzwge_pkg::MAX_CODE_BITS_DEF,
	parameter int TABLE_ENTRIES = lzwge_pkg::TABLE_ENTRIES_DEF,
	localparam int LW = $clog2(TABLE_ENTRIES + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            pixel,
	input  logic                  last,
	output lzwge_pkg::put_t       put,
	input  logic                  pk_ready,
	output lzwge_pkg::dict_wr_t   wr,
	output logic [LW-1:0]         fc_raddr,
	output logic [LW-1:0]         link_raddr,
	input  logic [LW-1:0]         fc_rdata,
	input  logic [PIXEL_BITS-1:0] sym_rdata,
	input  logic [LW-1:0]         sib_rdata
);

	localparam logic [LW-1:0] NO_LINK    = LW'(TABLE_ENTRIES);
	localparam logic [LW-1:0] CLEAR_CODE = LW'(1 << PIXEL_BITS);
	localparam logic [LW-1:0] EOI_CODE   = LW'((1 << PIXEL_BITS) + 1);
	localparam logic [LW-1:0] FIRST_FREE = LW'((1 << PIXEL_BITS) + 2);
	localparam logic [3:0]    START_W    = 4'(PIXEL_BITS + 1);
	localparam logic [3:0]    MAX_W      = 4'(MAX_CODE_BITS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLR0, ST_LOOK, ST_FC, ST_CHK, ST_CMP, ST_EMIT,
		ST_INS1, ST_INS2, ST_UPD, ST_CLRF, ST_LASTP, ST_EOI
	} state_t;

	state_t                state_q;
	logic [PIXEL_BITS-1:0] px_q;
	logic                  last_q;
	logic                  started_q;
	logic [LW-1:0]         prefix_q;
	logic [LW-1:0]         nfc_q;
	logic [3:0]            width_q;
	logic [LW-1:0]         link_q;
	logic [LW-1:0]         head_q;
	logic [LW:0]           steps_q;
	logic                  grow;

	assign in_stall   = (state_q != ST_IDLE);
	assign fc_raddr   = prefix_q;
	assign link_raddr = link_q;
	assign grow       = (17'(nfc_q) >= (17'd1 << width_q));

	always_comb begin
		put = '0;
		put.width = width_q;
		unique case (state_q)
			ST_CLR0, ST_CLRF: begin
				put.put  = 1'b1;
				put.code = lzwge_pkg::CODE_W'(CLEAR_CODE);
			end
			ST_EMIT: begin
				put.put  = 1'b1;
				put.code = lzwge_pkg::CODE_W'(prefix_q);
			end
			ST_LASTP: begin
				put.put  = last_q;
				put.code = lzwge_pkg::CODE_W'(prefix_q);
			end
			ST_EOI: begin
				put.put  = 1'b1;
				put.code = lzwge_pkg::CODE_W'(EOI_CODE);
				put.fin  = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		wr = '0;
		unique case (state_q)
			ST_INS1: begin
				wr.ent_we   = 1'b1;
				wr.ent_addr = lzwge_pkg::ADDR_W'(nfc_q);
				wr.sym      = lzwge_pkg::SYM_W'(px_q);
				wr.sib      = lzwge_pkg::LINK_W'(head_q);
				wr.fc_we    = 1'b1;
				wr.fc_addr  = lzwge_pkg::ADDR_W'(nfc_q);
				wr.fc_data  = lzwge_pkg::LINK_W'(NO_LINK);
			end
			ST_INS2: begin
				wr.fc_we   = 1'b1;
				wr.fc_addr = lzwge_pkg::ADDR_W'(prefix_q);
				wr.fc_data = lzwge_pkg::LINK_W'(nfc_q);
			end
			ST_CLRF: wr.clear_roots = pk_ready;
			ST_EOI:  wr.clear_roots = pk_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			px_q      <= '0;
			last_q    <= 1'b0;
			started_q <= 1'b0;
			prefix_q  <= NO_LINK;
			nfc_q     <= FIRST_FREE;
			width_q   <= START_W;
			link_q    <= NO_LINK;
			head_q    <= NO_LINK;
			steps_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						px_q    <= pixel[PIXEL_BITS-1:0];
						last_q  <= last;
						state_q <= started_q ? ST_LOOK : ST_CLR0;
					end
				end
				ST_CLR0: begin
					if (pk_ready) begin
						started_q <= 1'b1;
						state_q   <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (prefix_q >= NO_LINK) begin
						prefix_q <= LW'(px_q);
						state_q  <= ST_LASTP;
					end else begin
						state_q <= ST_FC;
					end
				end
				ST_FC: begin
					link_q  <= fc_rdata;
					head_q  <= fc_rdata;
					steps_q <= '0;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					if (link_q >= NO_LINK || steps_q >= (LW+1)'(TABLE_ENTRIES)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (sym_rdata == px_q) begin
						prefix_q <= link_q;
						state_q  <= ST_LASTP;
					end else begin
						link_q  <= sib_rdata;
						steps_q <= steps_q + 1'b1;
						state_q <= ST_CHK;
					end
				end
				ST_EMIT: begin
					if (pk_ready) begin
						state_q <= (nfc_q < NO_LINK) ? ST_INS1 : ST_UPD;
					end
				end
				ST_INS1: state_q <= ST_INS2;
				ST_INS2: begin
					nfc_q   <= nfc_q + 1'b1;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (grow && width_q < MAX_W) begin
						width_q <= width_q + 1'b1;
					end
					if ((nfc_q >= NO_LINK) || (grow && width_q >= MAX_W)) begin
						state_q <= ST_CLRF;
					end else begin
						prefix_q <= LW'(px_q);
						state_q  <= ST_LASTP;
					end
				end
				ST_CLRF: begin
					if (pk_ready) begin
						nfc_q    <= FIRST_FREE;
						width_q  <= START_W;
						prefix_q <= LW'(px_q);
						state_q  <= ST_LASTP;
					end
				end
				ST_LASTP: begin
					if (!last_q) begin
						state_q <= ST_IDLE;
					end else if (pk_ready) begin
						state_q <= ST_EOI;
					end
				end
				ST_EOI: begin
					if (pk_ready) begin
						started_q <= 1'b0;
						prefix_q  <= NO_LINK;
						nfc_q     <= FIRST_FREE;
						width_q   <= START_W;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hdl/lzw_gif_encoder_core.sv]
// GIF LZW encoder, top level: sequencer, trie dictionary and bit packer.
// Depends on lzwge_pkg, lzwge_ctrl, lzwge_dict, lzwge_pack.
//
// Input channel (in_valid/in_stall): one palette index per transaction in
// pixel, with last set on the final pixel of an image. Output channel
// (out_valid/out_stall): the packed code stream, one byte per transaction,
// LSB first, last_byte set on the final byte of the image.
// The first pixel of an image is preceded by a clear code. Each later
// pixel is accepted, reads the first child of the current prefix and walks
// its sibling chain, one check and one compare step per link, before the
// hand-off. A miss adds code output, entry insertion and width update; a
// dictionary restart adds a clear code and the last pixel an end code.
// The walk is paced by the registered reads of the memories.
// Codes are handed to a packer that drains one byte per cycle into an
// output register while out_stall is low; a stalled receiver holds the
// current byte and stops the sequencer only when the packer holds a full byte.
// Reset (arst_n low) empties the dictionary, the packer and the output;
// the block is ready as soon as reset releases. Once an image's end code
// is taken by the packer, the state returns to reset values for the next image.
module lzw_gif_encoder_core #(
	parameter int PIXEL_BITS    = lzwge_pkg::PIXEL_BITS_DEF,
	parameter int MAX_CODE_BITS = lzwge_pkg::MAX_CODE_BITS_DEF,
	parameter int TABLE_ENTRIES = lzwge_pkg::TABLE_ENTRIES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] pixel,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       last_byte
);

	localparam int LW = $clog2(TABLE_ENTRIES + 1);

	lzwge_pkg::put_t     put;
	lzwge_pkg::dict_wr_t wr;
	logic                  pk_ready;
	logic [LW-1:0]         fc_raddr;
	logic [LW-1:0]         link_raddr;
	logic [LW-1:0]         fc_rdata;
	logic [PIXEL_BITS-1:0] sym_rdata;
	logic [LW-1:0]         sib_rdata;

	lzwge_ctrl #(
		.PIXEL_BITS(PIXEL_BITS),
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .last(last),
		.put(put), .pk_ready(pk_ready), .wr(wr),
		.fc_raddr(fc_raddr), .link_raddr(link_raddr),
		.fc_rdata(fc_rdata), .sym_rdata(sym_rdata), .sib_rdata(sib_rdata)
	);

	lzwge_dict #(
		.PIXEL_BITS(PIXEL_BITS),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dict (
		.clk(clk), .arst_n(arst_n), .wr(wr),
		.fc_raddr(fc_raddr), .link_raddr(link_raddr),
		.fc_rdata(fc_rdata), .sym_rdata(sym_rdata), .sib_rdata(sib_rdata)
	);

	lzwge_pack u_pack (
		.clk(clk), .arst_n(arst_n), .put(put), .ready(pk_ready),
		.out_valid(out_valid), .out_stall(out_stall),
		.data_byte(data_byte), .last_byte(last_byte)
	);

endmodule
